### src/pcmls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcmls_pkg: shared types and constants
// Field widths, mute codes, register indexes and the structs passed between
// the configuration block, the monitor core and the top level.
// ----------------------------------------------------------------------------
package pcmls_pkg;

  // field and register widths
  localparam int unsigned ThrW   = 20;
  localparam int unsigned DistW  = 3;
  localparam int unsigned LimitW = 16;
  localparam int unsigned HoldW  = 8;
  localparam int unsigned CfgW   = 20;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned RateW  = 24;
  localparam int unsigned SecW   = 32;
  localparam int unsigned MuteW  = 2;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_LOCK_THRESHOLD  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_DISTINCT_NEEDED = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_SILENT_LIMIT    = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_HOLDOFF_SECONDS = 2'd3;

  // register reset values
  localparam logic [ThrW-1:0]   THR_RESET   = 20'd36000;
  localparam logic [DistW-1:0]  DIST_RESET  = 3'd5;
  localparam logic [LimitW-1:0] LIMIT_RESET = 16'd5000;
  localparam logic [HoldW-1:0]  HOLD_RESET  = 8'd1;

  // mute codes
  localparam logic [MuteW-1:0] MUTE_UNDEF = 2'd0;
  localparam logic [MuteW-1:0] MUTE_OFF   = 2'd1;
  localparam logic [MuteW-1:0] MUTE_ON    = 2'd2;

  // item kinds
  localparam logic MODE_DATA = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // limits
  localparam logic [RateW-1:0]  RATE_MAX   = {RateW{1'b1}};
  localparam logic [LimitW-1:0] RUN_MAX    = {LimitW{1'b1}};
  localparam logic [DistW-1:0]  CHANGE_CAP = 3'd6;
  localparam logic [7:0]        BYTE_LOW   = 8'd0;
  localparam logic [7:0]        BYTE_HIGH  = 8'd255;

  typedef struct packed {
    logic [ThrW-1:0]   lock_threshold;
    logic [DistW-1:0]  distinct_needed;
    logic [LimitW-1:0] silent_limit;
    logic [HoldW-1:0]  holdoff_seconds;
  } cfg_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] sample_byte;
    logic       buffer_last;
  } item_t;

  typedef struct packed {
    logic             phase_locked;
    logic [MuteW-1:0] mute_state;
    logic             mute_changed;
    logic             buffer_silent;
  } result_t;

endpackage

### src/pcm_lock_and_silence_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_lock_and_silence_monitor: PCM lock and silence monitor
// An input transfer loads the input register; the item moves on to the result
// register, raising out_valid, once the result register is free.
// Throughput: one item per cycle; the input register and result register
// form a two-stage pipeline that stalls only when the result side stalls.
// Reset (synchronous, rst_n low): registers to defaults, all state cleared,
// mute state undefined, both pipeline stages empty.
// ----------------------------------------------------------------------------
module pcm_lock_and_silence_monitor (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_mode,
  input  logic [7:0]                     in_sample_byte,
  input  logic                           in_buffer_last,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_phase_locked,
  output logic [pcmls_pkg::MuteW-1:0]    out_mute_state,
  output logic                           out_mute_changed,
  output logic                           out_buffer_silent,
  input  logic                           cfg_we,
  input  logic [pcmls_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [pcmls_pkg::CfgW-1:0]     cfg_wdata
);
  import pcmls_pkg::*;

  cfg_t    cfg;
  item_t   item_r;
  logic    item_vld_r;
  result_t res, res_r;
  logic    res_vld_r;
  logic    res_free;
  logic    take;

  pcmls_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // flow control
  assign res_free = !res_vld_r || !out_stall;
  assign take     = item_vld_r && res_free;
  assign in_stall = item_vld_r && !res_free;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (!in_stall) begin
      item_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r.mode        <= in_mode;
      item_r.sample_byte <= in_sample_byte;
      item_r.buffer_last <= in_buffer_last;
    end
  end

  pcmls_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .item_en (take),
    .item    (item_r),
    .res     (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (res_free) begin
      res_vld_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res;
    end
  end

  assign out_valid         = res_vld_r;
  assign out_phase_locked  = res_r.phase_locked;
  assign out_mute_state    = res_r.mute_state;
  assign out_mute_changed  = res_r.mute_changed;
  assign out_buffer_silent = res_r.buffer_silent;

  // a waiting item is handed on whenever the result slot frees
  assert property (@(posedge clk) disable iff (!rst_n)
    (item_vld_r && res_free) |=> res_vld_r)
    else $error("item not moved to result register");

  // input stalls only while both stages hold a transfer
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (item_vld_r && res_vld_r && out_stall))
    else $error("input stalled without cause");

  // a result is never marked silent unless locked
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_buffer_silent) |-> out_phase_locked)
    else $error("silent buffer reported while unlocked");

endmodule

### src/pcmls_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcmls_cfg_regs: configuration registers
// Holds the four monitor settings, written through a plain write port.
// ----------------------------------------------------------------------------
module pcmls_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [pcmls_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [pcmls_pkg::CfgW-1:0]     cfg_wdata,
  output pcmls_pkg::cfg_t                cfg
);
  import pcmls_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  // register decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_LOCK_THRESHOLD:  cfg_nxt.lock_threshold  = cfg_wdata[ThrW-1:0];
        REG_DISTINCT_NEEDED: cfg_nxt.distinct_needed = cfg_wdata[DistW-1:0];
        REG_SILENT_LIMIT:    cfg_nxt.silent_limit    = cfg_wdata[LimitW-1:0];
        REG_HOLDOFF_SECONDS: cfg_nxt.holdoff_seconds = cfg_wdata[HoldW-1:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lock_threshold  <= THR_RESET;
      cfg_r.distinct_needed <= DIST_RESET;
      cfg_r.silent_limit    <= LIMIT_RESET;
      cfg_r.holdoff_seconds <= HOLD_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### src/pcmls_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcmls_core: lock and silence state
// Holds the monitor state and computes the next state and the result for
// one item in a single pass; state moves on when the item is taken.
// ----------------------------------------------------------------------------
module pcmls_core (
  input  logic                clk,
  input  logic                rst_n,
  input  pcmls_pkg::cfg_t     cfg,
  input  logic                item_en,
  input  pcmls_pkg::item_t    item,
  output pcmls_pkg::result_t  res
);
  import pcmls_pkg::*;

  logic [RateW-1:0]  rate_r, rate_nxt;
  logic              locked_r, locked_nxt;
  logic [7:0]        prior_r, prior_nxt;
  logic [DistW-1:0]  chg_r, chg_nxt;
  logic [LimitW-1:0] run_r, run_nxt;
  logic [MuteW-1:0]  mute_r, mute_nxt;
  logic [SecW-1:0]   sec_r, sec_nxt;
  logic [SecW-1:0]   last_chg_r, last_chg_nxt;
  logic              ever_r, ever_nxt;

  logic              below_cap;
  logic              byte_counts;
  logic [DistW-1:0]  chg_upd;
  logic [LimitW-1:0] run_upd;
  logic              silent;
  logic [MuteW-1:0]  want;
  logic [SecW-1:0]   elapsed;
  logic              allowed;
  logic              changed;
  logic              judged;

  // per-byte change detection and buffer verdict
  always_comb begin
    below_cap   = (chg_r < CHANGE_CAP);
    byte_counts = below_cap && (item.sample_byte != BYTE_LOW) &&
                  (item.sample_byte != BYTE_HIGH) && (item.sample_byte != prior_r);
    chg_upd     = chg_r + {{(DistW-1){1'b0}}, byte_counts};
    judged      = (item.mode == MODE_DATA) && item.buffer_last && locked_r;
    silent      = judged && (chg_upd < cfg.distinct_needed);
    if (!judged)
      run_upd = run_r;
    else if (silent)
      run_upd = (run_r != RUN_MAX) ? run_r + 1'b1 : run_r;
    else
      run_upd = '0;
    want    = (run_upd < cfg.silent_limit) ? MUTE_OFF : MUTE_ON;
    elapsed = sec_r - last_chg_r;
    allowed = !ever_r || (elapsed > {{(SecW-HoldW){1'b0}}, cfg.holdoff_seconds});
    changed = judged && allowed && (want != mute_r);
  end

  // next state
  always_comb begin
    rate_nxt     = rate_r;
    locked_nxt   = locked_r;
    prior_nxt    = prior_r;
    chg_nxt      = chg_r;
    run_nxt      = run_r;
    mute_nxt     = mute_r;
    sec_nxt      = sec_r;
    last_chg_nxt = last_chg_r;
    ever_nxt     = ever_r;
    if (item.mode == MODE_TICK) begin
      locked_nxt = ({2'b00, cfg.lock_threshold} < rate_r[RateW-1:2]);
      rate_nxt   = '0;
      sec_nxt    = sec_r + 1'b1;
    end else begin
      if (rate_r != RATE_MAX) rate_nxt = rate_r + 1'b1;
      chg_nxt = chg_upd;
      if (below_cap) prior_nxt = item.sample_byte;
      run_nxt = run_upd;
      if (changed) begin
        mute_nxt     = want;
        last_chg_nxt = sec_r;
        ever_nxt     = 1'b1;
      end
      if (item.buffer_last) begin
        chg_nxt   = '0;
        prior_nxt = '0;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r     <= '0;
      locked_r   <= 1'b0;
      prior_r    <= '0;
      chg_r      <= '0;
      run_r      <= '0;
      mute_r     <= MUTE_UNDEF;
      sec_r      <= '0;
      last_chg_r <= '0;
      ever_r     <= 1'b0;
    end else if (item_en) begin
      rate_r     <= rate_nxt;
      locked_r   <= locked_nxt;
      prior_r    <= prior_nxt;
      chg_r      <= chg_nxt;
      run_r      <= run_nxt;
      mute_r     <= mute_nxt;
      sec_r      <= sec_nxt;
      last_chg_r <= last_chg_nxt;
      ever_r     <= ever_nxt;
    end
  end

  // result for the item being taken
  assign res.phase_locked  = locked_nxt;
  assign res.mute_state    = mute_nxt;
  assign res.mute_changed  = changed;
  assign res.buffer_silent = silent;

  // change counter never passes its cap
  assert property (@(posedge clk) disable iff (!rst_n) chg_r <= CHANGE_CAP)
    else $error("changing byte count above cap");

  // once a mute state is set it never returns to undefined
  assert property (@(posedge clk) disable iff (!rst_n)
    (mute_r != MUTE_UNDEF) |=> (mute_r != MUTE_UNDEF))
    else $error("mute state fell back to undefined");

  // a taken change is recorded as the current second
  assert property (@(posedge clk) disable iff (!rst_n)
    (item_en && changed) |=> (ever_r && (last_chg_r == sec_r)))
    else $error("mute change not recorded");

  // state only moves when an item is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    !item_en |=> ($stable(mute_r) && $stable(sec_r) && $stable(rate_r)))
    else $error("state changed without an item");

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for the pcm lock and silence monitor
// Drives byte and tick transfers through the block under random idling and
// back-pressure. Each accepted transfer is run through a cycle-free model of
// the lock, silence and mute logic, and every status transfer is checked in
// order against it. The register set changes between phases, including the
// extremes. A closing stretch of silent one-byte buffers drives the silent
// run past the mute limit.
// ----------------------------------------------------------------------------
module tb_top;
  import pcmls_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned TAIL_CYCLES   = 8;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned REPORT_MAX    = 50;

  // expected lock and mute status, one entry per accepted transfer
  class lock_mute_scoreboard;
    cfg_t              regs;
    logic [RateW-1:0]  byte_count;
    logic              locked;
    logic [7:0]        prev_byte;
    logic [DistW-1:0]  change_count;
    logic [LimitW-1:0] silent_run;
    logic [MuteW-1:0]  mute;
    logic [SecW-1:0]   seconds;
    logic [SecW-1:0]   last_change;
    logic              changed_once;
    result_t           expected_status_q[$];
    int unsigned       mismatches;

    function new();
      regs.lock_threshold  = THR_RESET;
      regs.distinct_needed = DIST_RESET;
      regs.silent_limit    = LIMIT_RESET;
      regs.holdoff_seconds = HOLD_RESET;
      byte_count   = '0;
      locked       = 1'b0;
      prev_byte    = '0;
      change_count = '0;
      silent_run   = '0;
      mute         = MUTE_UNDEF;
      seconds      = '0;
      last_change  = '0;
      changed_once = 1'b0;
      mismatches   = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
      case (idx)
        REG_LOCK_THRESHOLD:  regs.lock_threshold  = data[ThrW-1:0];
        REG_DISTINCT_NEEDED: regs.distinct_needed = data[DistW-1:0];
        REG_SILENT_LIMIT:    regs.silent_limit    = data[LimitW-1:0];
        REG_HOLDOFF_SECONDS: regs.holdoff_seconds = data[HoldW-1:0];
        default: ;
      endcase
    endfunction

    function void note_item(item_t it);
      result_t   r;
      logic [MuteW-1:0] want;
      logic      allowed;
      r = '0;
      if (it.mode == MODE_TICK) begin
        // one second elapsed: bytes counted become samples
        locked     = ((byte_count >> 2) > regs.lock_threshold);
        byte_count = '0;
        seconds    = seconds + 1'b1;
      end else begin
        if (byte_count != RATE_MAX) byte_count = byte_count + 1'b1;
        if (change_count < CHANGE_CAP) begin
          if (it.sample_byte != BYTE_LOW && it.sample_byte != BYTE_HIGH &&
              it.sample_byte != prev_byte) change_count = change_count + 1'b1;
          prev_byte = it.sample_byte;
        end
        if (it.buffer_last) begin
          // buffers are only judged while locked
          if (locked) begin
            if (change_count < regs.distinct_needed) begin
              r.buffer_silent = 1'b1;
              if (silent_run != RUN_MAX) silent_run = silent_run + 1'b1;
            end else begin
              silent_run = '0;
            end
            want = (silent_run < regs.silent_limit) ? MUTE_OFF : MUTE_ON;
            allowed = !changed_once || ((seconds - last_change) > regs.holdoff_seconds);
            if (allowed && want != mute) begin
              mute           = want;
              last_change    = seconds;
              changed_once   = 1'b1;
              r.mute_changed = 1'b1;
            end
          end
          change_count = '0;
          prev_byte    = '0;
        end
      end
      r.phase_locked = locked;
      r.mute_state   = mute;
      expected_status_q.push_back(r);
    endfunction

    function void check_status(result_t got);
      result_t want;
      if (expected_status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: status with none expected:",
                   " locked=%0b mute=%0d changed=%0b silent=%0b",
                   $time, got.phase_locked, got.mute_state, got.mute_changed,
                   got.buffer_silent);
        return;
      end
      want = expected_status_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: expected locked=%0b mute=%0d changed=%0b silent=%0b,",
                   $time, want.phase_locked, want.mute_state, want.mute_changed,
                   want.buffer_silent,
                   " actual locked=%0b mute=%0d changed=%0b silent=%0b",
                   got.phase_locked, got.mute_state, got.mute_changed,
                   got.buffer_silent);
      end
    endfunction

    function int unsigned pending();
      return expected_status_q.size();
    endfunction
  endclass

  logic                clk;
  logic                rst_n          = 1'b0;
  logic                in_valid       = 1'b0;
  logic                in_stall;
  logic                in_mode        = MODE_DATA;
  logic [7:0]          in_sample_byte = '0;
  logic                in_buffer_last = 1'b0;
  logic                out_valid;
  logic                out_stall      = 1'b0;
  logic                out_phase_locked;
  logic [MuteW-1:0]    out_mute_state;
  logic                out_mute_changed;
  logic                out_buffer_silent;
  logic                cfg_we         = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index      = REG_LOCK_THRESHOLD;
  logic [CfgW-1:0]     cfg_wdata      = '0;

  lock_mute_scoreboard sb;
  int unsigned         in_idle_pct    = 0;
  int unsigned         out_stall_pct  = 0;
  int unsigned         items_sent     = 0;
  int unsigned         quiet_cycles   = 0;

  // opening sequence: extremes, unlocked buffer, lock mid-buffer, first change
  item_t opening [24] = '{
    {MODE_TICK, 8'hFF, 1'b1}, {MODE_DATA, 8'h00, 1'b0}, {MODE_DATA, 8'hFF, 1'b0},
    {MODE_DATA, 8'h01, 1'b1}, {MODE_DATA, 8'h01, 1'b0}, {MODE_DATA, 8'hFE, 1'b0},
    {MODE_DATA, 8'h01, 1'b0}, {MODE_DATA, 8'h80, 1'b0}, {MODE_TICK, 8'h00, 1'b0},
    {MODE_DATA, 8'h80, 1'b1}, {MODE_DATA, 8'h00, 1'b1}, {MODE_DATA, 8'hFF, 1'b1},
    {MODE_DATA, 8'h37, 1'b0}, {MODE_DATA, 8'h37, 1'b0}, {MODE_DATA, 8'h37, 1'b1},
    {MODE_TICK, 8'h5A, 1'b1}, {MODE_DATA, 8'h00, 1'b0}, {MODE_DATA, 8'hFF, 1'b0},
    {MODE_DATA, 8'h00, 1'b0}, {MODE_DATA, 8'hFF, 1'b0}, {MODE_TICK, 8'h00, 1'b1},
    {MODE_DATA, 8'h00, 1'b1}, {MODE_TICK, 8'hA5, 1'b1}, {MODE_DATA, 8'h55, 1'b1}
  };

  pcm_lock_and_silence_monitor dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_sample_byte   (in_sample_byte),
    .in_buffer_last   (in_buffer_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_phase_locked (out_phase_locked),
    .out_mute_state   (out_mute_state),
    .out_mute_changed (out_mute_changed),
    .out_buffer_silent(out_buffer_silent),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // transfer monitor, result back-pressure and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        sb.note_item({in_mode, in_sample_byte, in_buffer_last});
      if (out_valid && !out_stall)
        sb.check_status({out_phase_locked, out_mute_state, out_mute_changed,
                         out_buffer_silent});
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("pcm_lock_and_silence_monitor regression: fail");
        $finish;
      end
    end
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  function automatic item_t random_tick();
    item_t it;
    it.mode        = MODE_TICK;
    it.sample_byte = 8'($urandom);
    it.buffer_last = 1'($urandom);
    return it;
  endfunction

  // one transfer on the input side, with random idle cycles ahead of it
  task automatic send_item(input item_t it);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= it.mode;
    in_sample_byte <= it.sample_byte;
    in_buffer_last <= it.buffer_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // drain the block, then write all four registers, with junk above the widths of all but the lock threshold
  task automatic configure(input logic [ThrW-1:0] thr, input logic [DistW-1:0] need,
                           input logic [LimitW-1:0] lim, input logic [HoldW-1:0] hold);
    logic [CfgIdxW-1:0] idx [4];
    logic [CfgW-1:0]    val [4];
    idx = '{REG_LOCK_THRESHOLD, REG_DISTINCT_NEEDED, REG_SILENT_LIMIT,
            REG_HOLDOFF_SECONDS};
    foreach (val[i]) val[i] = CfgW'($urandom);
    val[REG_LOCK_THRESHOLD]                 = thr;
    val[REG_DISTINCT_NEEDED][DistW-1:0]     = need;
    val[REG_SILENT_LIMIT][LimitW-1:0]       = lim;
    val[REG_HOLDOFF_SECONDS][HoldW-1:0]     = hold;
    in_valid <= 1'b0;
    // let the last input transfer be noted before checking what is pending
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
      sb.write_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // mostly well-formed buffers with random content, ticks and some noise
  task automatic run_traffic(input int unsigned n_items, input int unsigned tick_pct,
                             input int unsigned burst_max);
    int unsigned target;
    int unsigned ticks;
    int unsigned len;
    int unsigned style;
    logic [7:0]  a;
    logic [7:0]  b;
    item_t       it;
    target = items_sent + n_items;
    while (items_sent < target) begin
      if ($urandom_range(99) < 6) begin
        it.mode        = 1'($urandom);
        it.sample_byte = 8'($urandom);
        it.buffer_last = 1'($urandom);
        send_item(it);
      end else if ($urandom_range(99) < tick_pct) begin
        // a burst of empty seconds drops lock; four to eight bytes follow, which bring it back under a low threshold
        ticks = $urandom_range(burst_max);
        repeat (ticks) send_item(random_tick());
        if (ticks != 0)
          repeat ($urandom_range(8, 4)) send_item({MODE_DATA, 8'($urandom), 1'b0});
        send_item(random_tick());
      end else begin
        len   = $urandom_range(10, 1);
        style = $urandom_range(3);
        a     = 8'($urandom);
        b     = 8'($urandom);
        for (int i = 0; i < len; i++) begin
          it.mode = MODE_DATA;
          case (style)
            0: it.sample_byte = $urandom_range(1) ? BYTE_HIGH : BYTE_LOW;
            1: it.sample_byte = a;
            2: it.sample_byte = 8'($urandom);
            default: begin
              case ($urandom_range(3))
                0: it.sample_byte = BYTE_LOW;
                1: it.sample_byte = BYTE_HIGH;
                2: it.sample_byte = a;
                default: it.sample_byte = b;
              endcase
            end
          endcase
          it.buffer_last = (i == len - 1);
          // occasional second boundary inside a buffer
          if (i != 0 && $urandom_range(99) < 4) send_item(random_tick());
          send_item(it);
        end
      end
    end
  endtask

  initial begin : stimulus
    logic [ThrW-1:0]   thr;
    logic [DistW-1:0]  need;
    logic [LimitW-1:0] lim;
    logic [HoldW-1:0]  hold;
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed opening, reset registers first, then a low lock threshold
    for (int i = 0; i < 24; i++) begin
      if (i == 4) configure('0, 3'd3, 16'd2, 8'd1);
      send_item(opening[i]);
    end

    // random phases across register settings and idling patterns
    for (int p = 0; p < 12; p++) begin
      thr  = (p == 0 || p == 5) ? ThrW'(0) :
             (p == 1) ? {ThrW{1'b1}} : ThrW'($urandom_range(10));
      need = DistW'(p % 8);
      lim  = (p == 2) ? RUN_MAX : (p == 3) ? LimitW'(0) :
             (p == 4) ? LimitW'(1) : LimitW'($urandom_range(6, 1));
      hold = (p == 5) ? {HoldW{1'b1}} : (p == 6) ? HoldW'(0) : HoldW'($urandom_range(3));
      configure(thr, need, lim, hold);
      case (p % 4)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 74; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 74; end
        default: begin in_idle_pct = 19; out_stall_pct = 19; end
      endcase
      run_traffic((p == 5) ? 400 : 110, (p == 5) ? 40 : 15,
                  (p == 5) ? 30 : (p == 9) ? 3 : 0);
    end

    // silent one-byte buffers while locked, past the mute limit
    configure('0, CHANGE_CAP, LimitW'(40), '0);
    in_idle_pct   = 0;
    out_stall_pct = 0;
    repeat (8) send_item({MODE_DATA, 8'($urandom), 1'b0});
    send_item(random_tick());
    for (int k = 1; k <= 60; k++) begin
      if (k % 16 == 0) send_item(random_tick());
      else send_item({MODE_DATA, $urandom_range(1) ? BYTE_HIGH : BYTE_LOW, 1'b1});
    end
    for (int v = 1; v <= 6; v++) send_item({MODE_DATA, 8'(v), (v == 6)});

    // wait for the last status, then idle on to catch strays
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("pcm_lock_and_silence_monitor regression: pass");
    end else begin
      $display("pcm_lock_and_silence_monitor regression: fail");
    end
    $finish;
  end

endmodule

### files.f
src/pcmls_pkg.sv
src/pcmls_cfg_regs.sv
src/pcmls_core.sv
src/pcm_lock_and_silence_monitor.sv
verif/tb_top.sv
